// ----- rtl/fcl_pkg.sv -----
package fcl_pkg;

    // Q8.8 alignment of the bias and of the final sum
    localparam int FRAC_SHIFT = 8;
    // Wrap width of the accumulator for very wide configurations
    localparam int ACC_LIMIT = 64;
    // Output columns are numbered by a 4-bit field
    localparam int OUT_LIMIT = 16;
    localparam int CFG_BITS = 5;

    typedef enum logic [1:0] {
        MODE_LOAD_X  = 2'd0,
        MODE_LOAD_W  = 2'd1,
        MODE_LOAD_B  = 2'd2,
        MODE_COMPUTE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_INNER = 2'd1,
        REG_COLS  = 2'd2,
        REG_NONE  = 2'd3
    } reg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;      // input transaction accepted this cycle
        logic       issue;     // read one X, W and B element
        logic       first;     // first product of a column
        logic       last_k;    // last product of a column
        logic       last_col;  // column is the last of the row
        logic [3:0] row;
        logic [3:0] col;
        logic [7:0] k;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic col_done;  // column result moves into the output register
        logic out_free;  // output register can take a result next cycle
    } status_t;

endpackage

// ----- rtl/fcl_in_if.sv -----
interface fcl_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic [3:0]                   row;
    logic [3:0]                   col;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output mode, output row, output col, output value,
                    input ready);
    modport sink (input valid, input mode, input row, input col, input value,
                  output ready);
endinterface

// ----- rtl/fcl_out_if.sv -----
interface fcl_out_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [3:0]                   out_row;
    logic [3:0]                   out_col;
    logic signed [VALUE_BITS-1:0] out_value;
    logic                         overflow;
    logic                         last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output overflow, output last, input ready);
    modport sink (input valid, input out_row, input out_col, input out_value,
                  input overflow, input last, output ready);
endinterface

// ----- rtl/fcl_ctrl.sv -----
module fcl_ctrl #(
    parameter int MAX_ROWS  = 16,
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [fcl_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                   in_valid,
    input  logic [1:0]                             in_mode,
    input  logic [3:0]                             in_row,
    output logic                                   in_ready,
    input  fcl_pkg::status_t                       status,
    output fcl_pkg::cmd_t                          cmd
);

    localparam int COL_MAX = (MAX_COLS < fcl_pkg::OUT_LIMIT) ? MAX_COLS
                                                              : fcl_pkg::OUT_LIMIT;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_ISSUE = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [fcl_pkg::CFG_BITS-1:0] rows_in_use_reg, inner_in_use_reg, cols_in_use_reg;
    logic [fcl_pkg::CFG_BITS-1:0] rows, inner, cols;
    logic [3:0] row_reg, row_next;
    logic [3:0] j_reg, j_next;
    logic [4:0] k_reg, k_next;
    logic       accept;
    logic       last_k;
    logic       last_col;

    function automatic logic [fcl_pkg::CFG_BITS-1:0] clamp_cfg(
        input logic [fcl_pkg::CFG_BITS-1:0] v,
        input int                            hi
    );
        logic [fcl_pkg::CFG_BITS-1:0] r;
        if (v == '0)
            r = fcl_pkg::CFG_BITS'(1);
        else if (int'(v) > hi)
            r = fcl_pkg::CFG_BITS'(hi);
        else
            r = v;
        return r;
    endfunction

    assign rows  = clamp_cfg(rows_in_use_reg, MAX_ROWS);
    assign inner = clamp_cfg(inner_in_use_reg, MAX_INNER);
    assign cols  = clamp_cfg(cols_in_use_reg, COL_MAX);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign last_k   = (k_reg == inner - 5'd1);
    assign last_col = ({1'b0, j_reg} == cols - 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg  <= 5'd16;
            inner_in_use_reg <= 5'd16;
            cols_in_use_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fcl_pkg::REG_ROWS:  rows_in_use_reg  <= cfg_data;
                fcl_pkg::REG_INNER: inner_in_use_reg <= cfg_data;
                fcl_pkg::REG_COLS:  cols_in_use_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Loads finish in the datapath; rows not in use give nothing
                if (accept && in_mode == fcl_pkg::MODE_COMPUTE && {1'b0, in_row} < rows)
                begin
                    row_next   = in_row;
                    j_next     = 4'd0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.out_free)
                begin
                    k_next     = 5'd0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                k_next = k_reg + 5'd1;
                if (last_k)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (status.col_done)
                begin
                    if (last_col)
                        state_next = S_IDLE;
                    else
                    begin
                        j_next     = j_reg + 4'd1;
                        state_next = S_START;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= 4'd0;
            j_reg     <= 4'd0;
            k_reg     <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cmd.load     = accept;
        cmd.issue    = (state_reg == S_ISSUE);
        cmd.first    = (k_reg == 5'd0);
        cmd.last_k   = last_k;
        cmd.last_col = last_col;
        cmd.row      = row_reg;
        cmd.col      = j_reg;
        cmd.k        = 8'(k_reg);
    end

`ifndef ASSERT_OFF
    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        status.col_done |-> (state_reg == S_DRAIN))
        else $error("column result arrived outside drain");

    a_issue_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |=> (state_reg == S_ISSUE || state_reg == S_DRAIN))
        else $error("issue run broke off before the last product");
`endif

endmodule

// ----- rtl/fcl_datapath.sv -----
module fcl_datapath #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_INNER  = 16,
    parameter int MAX_COLS   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   in_mode,
    input  logic [3:0]                   in_row,
    input  logic [3:0]                   in_col,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  fcl_pkg::cmd_t                cmd,
    output fcl_pkg::status_t             status,
    fcl_out_if.source                    result_ch
);

    localparam int RAW = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
    localparam int IAW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CAW = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;
    localparam int ACC_FULL = 2 * VALUE_BITS + $clog2(MAX_INNER + 1);
    localparam int ACC_W = (ACC_FULL > fcl_pkg::ACC_LIMIT) ? fcl_pkg::ACC_LIMIT : ACC_FULL;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [VALUE_BITS-1:0] x_mem [2**(RAW+IAW)];
    logic signed [VALUE_BITS-1:0] w_mem [2**(IAW+CAW)];
    logic signed [VALUE_BITS-1:0] b_mem [2**(RAW+CAW)];

    logic [7:0] ld_row8, ld_col8, rd_row8, rd_col8;
    logic       we_x, we_w, we_b;

    logic signed [VALUE_BITS-1:0] x_rd_reg, w_rd_reg, b_rd_reg;
    logic                         v1_reg, first1_reg, lastk1_reg, lastc1_reg;
    logic [3:0]                   row1_reg, col1_reg;

    logic signed [2*VALUE_BITS-1:0] prod_reg;
    logic signed [VALUE_BITS-1:0]   b2_reg;
    logic                           v2_reg, first2_reg, lastk2_reg, lastc2_reg;
    logic [3:0]                     row2_reg, col2_reg;

    logic signed [ACC_W-1:0] acc_reg, acc_next, prod_ext, bias_ext;
    logic                    done3_reg, lastc3_reg;
    logic [3:0]              row3_reg, col3_reg;

    logic signed [ACC_W-1:0]      shifted;
    logic signed [VALUE_BITS-1:0] sat_value;
    logic                         sat_flag;

    logic                         out_valid_reg, out_valid_next;
    logic [3:0]                   out_row_reg, out_col_reg;
    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic                         out_ovf_reg, out_last_reg;

    assign ld_row8 = {4'd0, in_row};
    assign ld_col8 = {4'd0, in_col};
    assign rd_row8 = {4'd0, cmd.row};
    assign rd_col8 = {4'd0, cmd.col};

    // Drop loads that fall outside a store
    assign we_x = cmd.load && in_mode == fcl_pkg::MODE_LOAD_X
                  && 32'(in_row) < MAX_ROWS && 32'(in_col) < MAX_INNER;
    assign we_w = cmd.load && in_mode == fcl_pkg::MODE_LOAD_W
                  && 32'(in_row) < MAX_INNER && 32'(in_col) < MAX_COLS;
    assign we_b = cmd.load && in_mode == fcl_pkg::MODE_LOAD_B
                  && 32'(in_row) < MAX_ROWS && 32'(in_col) < MAX_COLS;

    always_ff @(posedge clk)
    begin
        if (we_x)
            x_mem[{ld_row8[RAW-1:0], ld_col8[IAW-1:0]}] <= in_value;
        if (cmd.issue)
            x_rd_reg <= x_mem[{rd_row8[RAW-1:0], cmd.k[IAW-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (we_w)
            w_mem[{ld_row8[IAW-1:0], ld_col8[CAW-1:0]}] <= in_value;
        if (cmd.issue)
            w_rd_reg <= w_mem[{cmd.k[IAW-1:0], rd_col8[CAW-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            b_mem[{ld_row8[RAW-1:0], ld_col8[CAW-1:0]}] <= in_value;
        if (cmd.issue)
            b_rd_reg <= b_mem[{rd_row8[RAW-1:0], rd_col8[CAW-1:0]}];
    end

    // Tags ride along with the read data and the product
    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.first;
        lastk1_reg <= cmd.last_k;
        lastc1_reg <= cmd.last_col;
        row1_reg   <= cmd.row;
        col1_reg   <= cmd.col;
        prod_reg   <= x_rd_reg * w_rd_reg;
        b2_reg     <= b_rd_reg;
        first2_reg <= first1_reg;
        lastk2_reg <= lastk1_reg;
        lastc2_reg <= lastc1_reg;
        row2_reg   <= row1_reg;
        col2_reg   <= col1_reg;
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign bias_ext = ACC_W'(b2_reg) <<< fcl_pkg::FRAC_SHIFT;
    assign acc_next = first2_reg ? (bias_ext + prod_ext) : (acc_reg + prod_ext);

    always_ff @(posedge clk)
    begin
        if (v2_reg)
            acc_reg <= acc_next;
        if (v2_reg && lastk2_reg)
        begin
            lastc3_reg <= lastc2_reg;
            row3_reg   <= row2_reg;
            col3_reg   <= col2_reg;
        end
    end

    assign shifted = acc_reg >>> fcl_pkg::FRAC_SHIFT;

    always_comb
    begin
        sat_flag  = 1'b0;
        sat_value = shifted[VALUE_BITS-1:0];
        priority if (shifted > SAT_HI)
        begin
            sat_flag  = 1'b1;
            sat_value = SAT_HI[VALUE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            sat_flag  = 1'b1;
            sat_value = SAT_LO[VALUE_BITS-1:0];
        end
        else
        begin
            sat_flag  = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done3_reg)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done3_reg)
        begin
            out_row_reg   <= row3_reg;
            out_col_reg   <= col3_reg;
            out_value_reg <= sat_value;
            out_ovf_reg   <= sat_flag;
            out_last_reg  <= lastc3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            done3_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            done3_reg     <= v2_reg && lastk2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.col_done = done3_reg;
    assign status.out_free = !out_valid_reg || result_ch.ready;

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.out_row   = out_row_reg;
    assign result_ch.out_col   = out_col_reg;
    assign result_ch.out_value = out_value_reg;
    assign result_ch.overflow  = out_ovf_reg;
    assign result_ch.last      = out_last_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done3_reg |-> (!out_valid_reg || result_ch.ready))
        else $error("column result would overwrite a pending output");

    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        done3_reg |-> !v2_reg)
        else $error("next column products overlap the finished sum");
`endif

endmodule

// ----- rtl/fully_connected_layer_top.sv -----
// Fully connected layer Y = X*W + B in signed Q8.8, one multiply-accumulate per cycle
// while a column issues. Load transactions write straight into the X, W or B store.
// A compute transaction runs each column one MAC per cycle through the memory read,
// multiplier and accumulator registers, plus a drain; each column first waits for the output register to free.
// rst_n clears control and valid flags at once; the stores hold no reset value.
module fully_connected_layer_top #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_INNER  = 16,
    parameter int MAX_COLS   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [fcl_pkg::CFG_BITS-1:0] cfg_data,
    fcl_in_if.sink                       data_ch,
    fcl_out_if.source                    result_ch
);

    // Command and status travel only through these two structs
    fcl_pkg::cmd_t    cmd;
    fcl_pkg::status_t status;

    // Sequencer: holds the size registers, steps columns and inner index,
    // waits for the output register to free before starting each column
    fcl_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (data_ch.valid),
        .in_mode   (data_ch.mode),
        .in_row    (data_ch.row),
        .in_ready  (data_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: three stores, multiplier, accumulator, saturation and
    // the output register that decouples the result side from the input side
    fcl_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_INNER  (MAX_INNER),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mode   (data_ch.mode),
        .in_row    (data_ch.row),
        .in_col    (data_ch.col),
        .in_value  (data_ch.value),
        .cmd       (cmd),
        .status    (status),
        .result_ch (result_ch)
    );

endmodule

// ----- tb/tb_fully_connected_layer_top.sv -----
`timescale 1ns / 100ps

module tb_fully_connected_layer_top;

    localparam int DIM          = 16;
    localparam int VALUE_BITS   = 16;
    localparam int HALF_PERIOD  = 5;
    // The drain wait covers the longest compute row; leave some margin on top
    localparam int DRAIN_CYCLES = DIM * (DIM + 4) + 40;
    localparam int PHASE_ITEMS  = 32;
    localparam int NUM_PHASES   = 6;
    // Timeout of several times the slowest correct run
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // Size settings of the random phases, out-of-range codes included on purpose
    localparam logic [4:0] PHASE_ROWS  [NUM_PHASES] = '{5'd3, 5'd31, 5'd16, 5'd0, 5'd8, 5'd17};
    localparam logic [4:0] PHASE_INNER [NUM_PHASES] = '{5'd2, 5'd0, 5'd16, 5'd5, 5'd4, 5'd31};
    localparam logic [4:0] PHASE_COLS  [NUM_PHASES] = '{5'd3, 5'd31, 5'd16, 5'd1, 5'd9, 5'd2};

    typedef struct packed {
        fcl_pkg::mode_t mode;
        logic [3:0]     row;
        logic [3:0]     col;
        logic [15:0]    value;
    } layer_item_t;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        ovf;
        logic        last;
    } layer_result_t;

    // How a directed row is checked: by the row predictor, by one typed-in result,
    // or by the absence of any result
    typedef enum {CHK_MODEL, CHK_ONE, CHK_NONE} check_t;
    typedef enum {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t          kind;
        layer_item_t         item;
        fcl_pkg::reg_index_t idx;
        logic [4:0]          data;
        check_t              chk;
        logic [15:0]         want_value;
        logic                want_ovf;
    } directed_step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [fcl_pkg::CFG_BITS-1:0] cfg_data;

    fcl_in_if  #(.VALUE_BITS(VALUE_BITS)) data_ch();
    fcl_out_if #(.VALUE_BITS(VALUE_BITS)) result_ch();

    fully_connected_layer_top #(
        .MAX_ROWS   (DIM),
        .MAX_INNER  (DIM),
        .MAX_COLS   (DIM),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_ch   (data_ch),
        .result_ch (result_ch)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Layer predictor: its own copy of X, W, B and of the size registers.
    // The written flags keep the stimulus from reading an entry never loaded.
    // ------------------------------------------------------------------
    logic signed [15:0] x_mem [DIM][DIM];
    logic signed [15:0] w_mem [DIM][DIM];
    logic signed [15:0] b_mem [DIM][DIM];
    bit                 x_set [DIM][DIM];
    bit                 w_set [DIM][DIM];
    bit                 b_set [DIM][DIM];
    logic [4:0]         rows_cfg  = 5'd16;
    logic [4:0]         inner_cfg = 5'd16;
    logic [4:0]         cols_cfg  = 5'd16;

    // Results still owed by the block, oldest first
    layer_result_t pending_outputs[$];
    directed_step_t directed_steps[$];

    int mismatch_count = 0;
    int src_calm = 0;
    int sink_calm = 0;
    int items_sent = 0;

    // Append one owed result at the tail
    function automatic void owe_result(input layer_result_t res);
        pending_outputs.insert(pending_outputs.size(), res);
    endfunction

    // Append one directed step at the tail
    function automatic void queue_step(input directed_step_t s);
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    // A size code of 0 acts as 1, anything above the store size acts as the store size
    function automatic int clamp_size(input logic [4:0] code);
        if (code == 5'd0)
            return 1;
        if (code > DIM)
            return DIM;
        return int'(code);
    endfunction

    // Per item random wait, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // Favor the saturation edges and small numbers, but keep plenty of raw random words
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic layer_item_t make_item(input fcl_pkg::mode_t mode, input int row,
                                              input int col, input logic [15:0] value);
        layer_item_t it;
        it.mode  = mode;
        it.row   = 4'(row);
        it.col   = 4'(col);
        it.value = value;
        return it;
    endfunction

    function automatic void store_element(input layer_item_t it);
        case (it.mode)
            fcl_pkg::MODE_LOAD_X:
            begin
                x_mem[it.row][it.col] = it.value;
                x_set[it.row][it.col] = 1'b1;
            end
            fcl_pkg::MODE_LOAD_W:
            begin
                w_mem[it.row][it.col] = it.value;
                w_set[it.row][it.col] = 1'b1;
            end
            fcl_pkg::MODE_LOAD_B:
            begin
                b_mem[it.row][it.col] = it.value;
                b_set[it.row][it.col] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Queue the outputs of one row: bias in Q16.16, full-width sum of products,
    // floor shift back to Q8.8, then saturate and flag
    function automatic void predict_row(input logic [3:0] r);
        int rows_n;
        int inner_n;
        int cols_n;
        longint acc;
        longint scaled;
        layer_result_t res;
        rows_n  = clamp_size(rows_cfg);
        inner_n = clamp_size(inner_cfg);
        cols_n  = clamp_size(cols_cfg);
        if (int'(r) >= rows_n)
            return;
        for (int j = 0; j < cols_n; j++)
        begin
            acc = longint'(b_mem[r][j]) <<< fcl_pkg::FRAC_SHIFT;
            for (int k = 0; k < inner_n; k++)
                acc += longint'(x_mem[r][k]) * longint'(w_mem[k][j]);
            scaled   = acc >>> fcl_pkg::FRAC_SHIFT;
            res.row  = r;
            res.col  = 4'(j);
            res.last = (j == cols_n - 1);
            res.ovf  = 1'b0;
            if (scaled > 32767)
            begin
                res.value = 16'h7fff;
                res.ovf   = 1'b1;
            end
            else if (scaled < -32768)
            begin
                res.value = 16'h8000;
                res.ovf   = 1'b1;
            end
            else
            begin
                res.value = scaled[15:0];
            end
            owe_result(res);
        end
    endfunction

    function automatic void add_cfg(input fcl_pkg::reg_index_t idx, input logic [4:0] data);
        directed_step_t s;
        s.kind = STEP_CFG;
        s.idx  = idx;
        s.data = data;
        s.item = '0;
        s.chk  = CHK_NONE;
        s.want_value = '0;
        s.want_ovf   = 1'b0;
        queue_step(s);
    endfunction

    function automatic void add_load(input fcl_pkg::mode_t mode, input int row, input int col,
                                     input logic [15:0] value);
        directed_step_t s;
        s.kind = STEP_ITEM;
        s.idx  = fcl_pkg::REG_NONE;
        s.data = '0;
        s.item = make_item(mode, row, col, value);
        s.chk  = CHK_MODEL;
        s.want_value = '0;
        s.want_ovf   = 1'b0;
        queue_step(s);
    endfunction

    // col and value of a compute transaction are junk on purpose: the block must ignore them
    function automatic void add_compute(input int row, input check_t chk,
                                        input logic [15:0] want_value, input logic want_ovf);
        directed_step_t s;
        s.kind = STEP_ITEM;
        s.idx  = fcl_pkg::REG_NONE;
        s.data = '0;
        s.item = make_item(fcl_pkg::MODE_COMPUTE, row, 15, 16'h5a5a);
        s.chk  = chk;
        s.want_value = want_value;
        s.want_ovf   = want_ovf;
        queue_step(s);
    endfunction

    function automatic void report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Drive one input transaction; returns at the falling edge after it was taken,
    // with valid still high so a zero gap runs straight into the next one
    task automatic send_item(input layer_item_t it, input check_t chk,
                             input logic [15:0] want_value, input logic want_ovf);
        int gap;
        layer_result_t res;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            data_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_ch.valid = 1'b1;
        data_ch.mode  = it.mode;
        data_ch.row   = it.row;
        data_ch.col   = it.col;
        data_ch.value = it.value;
        do
            @(posedge clk);
        while (data_ch.ready !== 1'b1);
        items_sent++;
        if (it.mode != fcl_pkg::MODE_COMPUTE)
            store_element(it);
        else if (chk == CHK_MODEL)
            predict_row(it.row);
        else if (chk == CHK_ONE)
        begin
            res.row   = it.row;
            res.col   = 4'd0;
            res.value = want_value;
            res.ovf   = want_ovf;
            res.last  = 1'b1;
            owe_result(res);
        end
        @(negedge clk);
    endtask

    // Drop valid, let every owed result arrive, then let a row that yields nothing drain
    task automatic wait_idle();
        data_ch.valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input fcl_pkg::reg_index_t idx, input logic [4:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            fcl_pkg::REG_ROWS:  rows_cfg  = data;
            fcl_pkg::REG_INNER: inner_cfg = data;
            fcl_pkg::REG_COLS:  cols_cfg  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_index = fcl_pkg::REG_NONE;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready stalls, compare each transaction against the
    // oldest owed result
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        layer_result_t got;
        layer_result_t want;
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(sink_calm);
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            got.row   = result_ch.out_row;
            got.col   = result_ch.out_col;
            got.value = result_ch.out_value;
            got.ovf   = result_ch.overflow;
            got.last  = result_ch.last;
            if (pending_outputs.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, got row %0d col %0d value %0d",
                         $time, got.row, got.col, $signed(got.value));
            end
            else
            begin
                want = pending_outputs.pop_front();
                report_field("out_row", want.row, got.row);
                report_field("out_col", want.col, got.col);
                report_field("out_value", int'($signed(want.value)), int'($signed(got.value)));
                report_field("overflow", want.ovf, got.ovf);
                report_field("last", want.last, got.last);
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int rows_n;
        int inner_n;
        int cols_n;
        int r;
        int pick;
        int stop_at;
        int k;
        int j;

        // Hold every input at a known value from time zero
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = fcl_pkg::REG_NONE;
        cfg_data      = '0;
        data_ch.valid = 1'b0;
        data_ch.mode  = fcl_pkg::MODE_LOAD_X;
        data_ch.row   = '0;
        data_ch.col   = '0;
        data_ch.value = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: a 1x1x1 layer first so each output reads straight off the inputs.
        // Rows code 0 must act as one row.
        add_cfg(fcl_pkg::REG_ROWS, 5'd0);
        add_cfg(fcl_pkg::REG_INNER, 5'd1);
        add_cfg(fcl_pkg::REG_COLS, 5'd1);
        // Largest positive everywhere: saturate high
        add_load(fcl_pkg::MODE_LOAD_X, 0, 0, 16'h7fff);
        add_load(fcl_pkg::MODE_LOAD_W, 0, 0, 16'h7fff);
        add_load(fcl_pkg::MODE_LOAD_B, 0, 0, 16'h7fff);
        add_compute(0, CHK_ONE, 16'h7fff, 1'b1);
        // Most negative weight and bias: saturate low
        add_load(fcl_pkg::MODE_LOAD_W, 0, 0, 16'h8000);
        add_load(fcl_pkg::MODE_LOAD_B, 0, 0, 16'h8000);
        add_compute(0, CHK_ONE, 16'h8000, 1'b1);
        // X = 1.0, no bias: the result sits exactly on each limit without saturating
        add_load(fcl_pkg::MODE_LOAD_B, 0, 0, 16'h0000);
        add_load(fcl_pkg::MODE_LOAD_X, 0, 0, 16'h0100);
        add_compute(0, CHK_ONE, 16'h8000, 1'b0);
        add_load(fcl_pkg::MODE_LOAD_W, 0, 0, 16'h7fff);
        add_compute(0, CHK_ONE, 16'h7fff, 1'b0);
        // Tiny negative product: the shift must round toward minus infinity
        add_load(fcl_pkg::MODE_LOAD_X, 0, 0, 16'hffff);
        add_load(fcl_pkg::MODE_LOAD_W, 0, 0, 16'h0001);
        add_compute(0, CHK_MODEL, '0, 1'b0);
        // Row outside the rows in use: no output at all
        add_compute(1, CHK_NONE, '0, 1'b0);
        add_cfg(fcl_pkg::REG_ROWS, 5'd2);
        add_load(fcl_pkg::MODE_LOAD_X, 1, 0, 16'h8000);
        add_load(fcl_pkg::MODE_LOAD_B, 1, 0, 16'h7fff);
        add_compute(1, CHK_MODEL, '0, 1'b0);
        add_compute(15, CHK_NONE, '0, 1'b0);
        // Two columns: last must sit on the second one only
        add_cfg(fcl_pkg::REG_COLS, 5'd2);
        add_load(fcl_pkg::MODE_LOAD_W, 0, 1, 16'h0080);
        add_load(fcl_pkg::MODE_LOAD_B, 0, 1, 16'hff00);
        add_compute(0, CHK_MODEL, '0, 1'b0);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_CFG)
            begin
                wait_idle();
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            end
            else
            begin
                send_item(directed_steps[i].item, directed_steps[i].chk,
                          directed_steps[i].want_value, directed_steps[i].want_ovf);
            end
        end

        // Random part: one size setting per phase, all three registers rewritten while idle
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            write_reg(fcl_pkg::REG_ROWS, PHASE_ROWS[phase]);
            write_reg(fcl_pkg::REG_INNER, PHASE_INNER[phase]);
            write_reg(fcl_pkg::REG_COLS, PHASE_COLS[phase]);
            rows_n  = clamp_size(rows_cfg);
            inner_n = clamp_size(inner_cfg);
            cols_n  = clamp_size(cols_cfg);
            stop_at = items_sent + PHASE_ITEMS;

            while (items_sent < stop_at)
            begin
                pick = $urandom_range(0, 9);
                if (pick >= 8)
                begin
                    // Noise: a load anywhere in any store, inside or outside the sizes in use
                    send_item(make_item(fcl_pkg::mode_t'($urandom_range(0, 2)),
                                        $urandom_range(0, DIM - 1),
                                        $urandom_range(0, DIM - 1), pick_value()),
                              CHK_MODEL, '0, 1'b0);
                end
                else
                begin
                    // Mostly a row in use; now and then any row, which may yield nothing
                    r = (pick < 7) ? $urandom_range(0, rows_n - 1) : $urandom_range(0, DIM - 1);
                    if (r < rows_n)
                    begin
                        // Load whatever this row reads that was never written
                        for (k = 0; k < inner_n; k++)
                            if (!x_set[r][k])
                                send_item(make_item(fcl_pkg::MODE_LOAD_X, r, k, pick_value()),
                                          CHK_MODEL, '0, 1'b0);
                        for (k = 0; k < inner_n; k++)
                            for (j = 0; j < cols_n; j++)
                                if (!w_set[k][j])
                                    send_item(make_item(fcl_pkg::MODE_LOAD_W, k, j,
                                                        pick_value()),
                                              CHK_MODEL, '0, 1'b0);
                        for (j = 0; j < cols_n; j++)
                            if (!b_set[r][j])
                                send_item(make_item(fcl_pkg::MODE_LOAD_B, r, j, pick_value()),
                                          CHK_MODEL, '0, 1'b0);
                        // Overwrite a few elements the row uses so results keep moving
                        repeat ($urandom_range(0, 3))
                        begin
                            case ($urandom_range(0, 2))
                                0: send_item(make_item(fcl_pkg::MODE_LOAD_X, r,
                                                       $urandom_range(0, inner_n - 1),
                                                       pick_value()), CHK_MODEL, '0, 1'b0);
                                1: send_item(make_item(fcl_pkg::MODE_LOAD_W,
                                                       $urandom_range(0, inner_n - 1),
                                                       $urandom_range(0, cols_n - 1),
                                                       pick_value()),
                                             CHK_MODEL, '0, 1'b0);
                                default: send_item(make_item(fcl_pkg::MODE_LOAD_B, r,
                                                             $urandom_range(0, cols_n - 1),
                                                             pick_value()), CHK_MODEL, '0, 1'b0);
                            endcase
                        end
                    end
                    send_item(make_item(fcl_pkg::MODE_COMPUTE, r, $urandom_range(0, DIM - 1),
                                        pick_value()),
                              CHK_MODEL, '0, 1'b0);
                end
            end
        end

        // Let the last rows come out, then settle the verdict
        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop in case the block hangs or owes results it never delivers
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
